// ----- rtl/core/zsoc_pkg.sv -----
// Shared types and constants of the zone smoothing occupancy counter.
package zsoc_pkg;

  // Default number of zones in the chain.
  localparam int unsigned ZoneCountDef = 64;

  // Field and register widths.
  localparam int unsigned DistW  = 12;
  localparam int unsigned FracW  = 8;
  localparam int unsigned SmoothW = DistW + FracW;
  localparam int unsigned GainW  = 9;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned TallyW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Gain of 1.0 in Q1.8 and the tally ceiling.
  localparam logic [GainW-1:0]  GainOne   = 9'd256;
  localparam logic [TallyW-1:0] TallyMax  = 7'd127;

  // Register reset values.
  localparam logic [GainW-1:0]  GainRst  = 9'd102;
  localparam logic [DistW-1:0]  NearRst  = 12'd500;
  localparam logic [DistW-1:0]  FarRst   = 12'd2500;
  localparam logic [ShiftW-1:0] ShiftRst = 3'd3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNear  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFar   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegShift = 2'd3;

  // Control broadcast from the top level to every zone cell.
  typedef struct packed {
    logic               step;   // an item is accepted this cycle
    logic               last;   // that item closes the frame
    logic [SmoothW-1:0] value;  // new smoothed value for the selected zone
  } zsoc_cell_ctrl_t;

endpackage

// ----- rtl/core/zsoc_cell.sv -----
// One zone cell: the zone's smoothed distance and its position token.
module zsoc_cell import zsoc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zsoc_cell_ctrl_t    ctrl_i,
  input  logic               sel_i,    // token of the neighbor: this zone is next
  output logic               token_o,  // this zone took the most recent item
  output logic [SmoothW-1:0] value_o   // stored value, zero when not selected
);

  logic               token_q, token_d;
  logic [SmoothW-1:0] value_q, value_d;

  // The token moves one cell on each item and is dropped at the end of a frame.
  always_comb begin
    token_d = token_q;
    value_d = value_q;
    if (ctrl_i.step) begin
      token_d = sel_i & ~ctrl_i.last;
      if (sel_i) begin
        value_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
      value_q <= '0;
    end else begin
      token_q <= token_d;
      value_q <= value_d;
    end
  end

  assign token_o = token_q;
  assign value_o = sel_i ? value_q : '0;

endmodule

// ----- rtl/core/zsoc_ema.sv -----
// Exponential moving average update of one zone in Q12.8.
module zsoc_ema import zsoc_pkg::*; (
  input  logic [GainW-1:0]   gain_i,
  input  logic [DistW-1:0]   dist_i,
  input  logic [SmoothW-1:0] prev_i,
  output logic [SmoothW-1:0] next_o
);

  localparam int unsigned AccW = SmoothW + GainW;

  logic [GainW-1:0] gain_eff;
  logic [GainW-1:0] gain_rest;
  logic [AccW-1:0]  new_part;
  logic [AccW-1:0]  old_part;
  logic [AccW-1:0]  acc;

  // Gains above 1.0 act as 1.0, so the new sample replaces the old value.
  assign gain_eff  = (gain_i > GainOne) ? GainOne : gain_i;
  assign gain_rest = GainOne - gain_eff;

  // Weighted sum, then truncate the extra fraction bits.
  assign new_part = AccW'(gain_eff) * AccW'({dist_i, {FracW{1'b0}}});
  assign old_part = AccW'(gain_rest) * AccW'(prev_i);
  assign acc      = new_part + old_part;
  assign next_o   = acc[FracW +: SmoothW];

endmodule

// ----- rtl/core/zone_smoothing_occupancy_count.sv -----
// Top level of the zone smoothing occupancy counter.
//
// Input stream: one zone distance per item (tdata bits 11:0), in zone order,
// with tlast on the final zone of a frame. Each zone keeps an exponential
// moving average of its distance in a row of zone cells; a position token
// steps from cell to cell with each item and returns to zone 0 after tlast.
// Output stream: one item per frame, sent for the zone marked with tlast,
// carrying the count of zones whose smoothed value lies strictly between
// the near and far limits, and that count shifted right.
// Throughput: one item per cycle unless the tally stage is stalled. The smoothing
// update of the selected zone is done in the accept cycle; the window test and
// tally use the tally stage input register, and the result of the last zone goes
// from there into the output register. While a result waits on a stalled receiver,
// zones keep flowing until the next frame end reaches the tally stage.
// Reset clears all smoothed values, the tally and the zone position, and loads the
// configuration registers with their defaults. The user must write configuration
// through cfg_we_i / cfg_index_i / cfg_data_i while the block is idle (not enforced).
module zone_smoothing_occupancy_count import zsoc_pkg::*; #(
  parameter int unsigned ZONE_COUNT = ZoneCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Zone items.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [11:0] range_mm, rest zero
  input  logic                s_axis_tlast,   // last_zone
  // Frame results.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [6:0] hit_zones, [13:7] head_estimate
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [GainW-1:0]  gain_q;
  logic [DistW-1:0]  near_q;
  logic [DistW-1:0]  far_q;
  logic [ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainRst;
      near_q  <= NearRst;
      far_q   <= FarRst;
      shift_q <= ShiftRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegGain:  gain_q  <= cfg_data_i[GainW-1:0];
        RegNear:  near_q  <= cfg_data_i[DistW-1:0];
        RegFar:   far_q   <= cfg_data_i[DistW-1:0];
        RegShift: shift_q <= cfg_data_i[ShiftW-1:0];
        default:  ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic                in_fire;
  logic                v1_q;
  logic                last1_q;
  logic [SmoothW-1:0]  s1_q;
  logic                adv1;
  logic                out_valid_q;
  logic [TallyW-1:0]   out_hits_q;
  logic [TallyW-1:0]   out_head_q;

  assign adv1          = v1_q & (~last1_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~v1_q | adv1;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // Frame start flag: the next item goes to zone 0.
  logic start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else if (in_fire) begin
      start_q <= s_axis_tlast;
    end
  end

  // Row of zone cells; the token of the last cell wraps to the first.
  logic [ZONE_COUNT-1:0] token;
  logic [ZONE_COUNT-1:0] sel;
  logic [SmoothW-1:0]    cell_val [ZONE_COUNT];
  zsoc_cell_ctrl_t       cell_ctrl;
  logic [SmoothW-1:0]    prev_val;
  logic [SmoothW-1:0]    next_val;

  assign sel[0] = start_q | token[ZONE_COUNT-1];
  assign sel[ZONE_COUNT-1:1] = token[ZONE_COUNT-2:0];

  assign cell_ctrl.step  = in_fire;
  assign cell_ctrl.last  = s_axis_tlast;
  assign cell_ctrl.value = next_val;

  for (genvar i = 0; i < ZONE_COUNT; i++) begin : g_cell
    zsoc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .sel_i   (sel[i]),
      .token_o (token[i]),
      .value_o (cell_val[i])
    );
  end

  // Gather the selected zone's value; all other cells drive zero.
  always_comb begin
    prev_val = '0;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      prev_val = prev_val | cell_val[i];
    end
  end

  zsoc_ema u_ema (
    .gain_i (gain_q),
    .dist_i (s_axis_tdata[DistW-1:0]),
    .prev_i (prev_val),
    .next_o (next_val)
  );

  // Tally stage input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q    <= next_val;
      last1_q <= s_axis_tlast;
    end
  end

  // Window test and saturating hit tally.
  logic              hit;
  logic [TallyW-1:0] tally_q;
  logic [TallyW-1:0] tally_sum;

  assign hit = (s1_q > {near_q, {FracW{1'b0}}}) & (s1_q < {far_q, {FracW{1'b0}}});
  assign tally_sum = (hit && tally_q != TallyMax) ? tally_q + 1'b1 : tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (adv1) begin
      tally_q <= last1_q ? '0 : tally_sum;
    end
  end

  // Output register, loaded at the end of each frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv1 && last1_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && last1_q) begin
      out_hits_q <= tally_sum;
      out_head_q <= tally_sum >> shift_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 2 * TallyW){1'b0}}, out_head_q, out_hits_q};

  // At most one zone holds the position token.
  a_token_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token))
    else $error("more than one zone cell holds the token");

  // At a frame start no cell may still hold a token.
  a_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (token == '0))
    else $error("token left in the row at frame start");

  // A frame end stuck behind a stalled result blocks new items.
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && last1_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("item accepted while the tally stage is stalled");

  // The head estimate never exceeds the hit count.
  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_head_q <= out_hits_q))
    else $error("head estimate above hit count");

endmodule
